// File: hdl/dss_pkg.sv
// Shared constants, types and codes for the diffusion stencil step block.
// No dependencies; compile first.
package dss_pkg;

    localparam int MAX_WIDTH  = 63;
    localparam int LINE_DEPTH = 2 * MAX_WIDTH;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int COL_W      = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W      = 16;
    localparam int SAMPLE_W   = 32;
    localparam int WEIGHT_W   = 32;
    localparam int GAIN_W     = 16;
    localparam int LAP_W      = 48;
    localparam int PROD_W     = SAMPLE_W + WEIGHT_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [ADDR_W-1:0] LOWER_BASE = ADDR_W'(MAX_WIDTH);

    localparam logic [COL_W-1:0]           RST_GRID_WIDTH  = COL_W'(32);
    localparam logic [ROW_W-1:0]           RST_GRID_HEIGHT = ROW_W'(32);
    localparam logic signed [WEIGHT_W-1:0] RST_WEIGHT_H    = 32'sd65536;
    localparam logic signed [WEIGHT_W-1:0] RST_WEIGHT_V    = 32'sd65536;
    localparam logic signed [WEIGHT_W-1:0] RST_WEIGHT_C    = -32'sd262144;
    localparam logic [GAIN_W-1:0]          RST_STEP_GAIN   = GAIN_W'(6553);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 3'd0,
        CFG_GRID_HEIGHT = 3'd1,
        CFG_WEIGHT_H    = 3'd2,
        CFG_WEIGHT_V    = 3'd3,
        CFG_WEIGHT_C    = 3'd4,
        CFG_STEP_GAIN   = 3'd5
    } cfg_idx_t;

    // stencil operand registers
    typedef enum logic [2:0] {
        OP_CENTRE = 3'd0,
        OP_UP     = 3'd1,
        OP_DOWN   = 3'd2,
        OP_LEFT   = 3'd3,
        OP_RIGHT  = 3'd4
    } op_t;

    typedef struct packed {
        logic              ld_sample;
        logic              clr_down;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        op_t               rd_tgt;
        logic              rd_zero;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_sample;
        logic              acc_clr;
        logic              mul_en;
        op_t               mul_op;
        logic              lap_en;
        logic              gain_en;
        logic              out_load;
        logic              border;
        logic              last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// File: hdl/dss_if.sv
// Valid/ready stream interfaces for samples and results.
// Depends on dss_pkg.
interface dss_sample_if
    import dss_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface dss_result_if
    import dss_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] new_value;
    logic signed [LAP_W-1:0]    laplacian;
    logic                       on_border;
    logic                       frame_last;

    modport source (output valid, output new_value, output laplacian,
                    output on_border, output frame_last, input ready);
    modport sink   (input valid, input new_value, input laplacian,
                    input on_border, input frame_last, output ready);
endinterface

// File: hdl/dss_datapath.sv
// Line store, stencil operands, multiply-accumulate, gain and output register.
// Depends on dss_pkg; driven by dss_ctrl commands.
module dss_datapath
    import dss_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    cmd,
    output dp_status_t                 status,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [WEIGHT_W-1:0] weight_h,
    input  logic signed [WEIGHT_W-1:0] weight_v,
    input  logic signed [WEIGHT_W-1:0] weight_c,
    input  logic [GAIN_W-1:0]          step_gain,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] new_value,
    output logic signed [LAP_W-1:0]    laplacian,
    output logic                       on_border,
    output logic                       frame_last
);

    logic [SAMPLE_W-1:0] mem [LINE_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                cap_en_reg;
    op_t                 cap_tgt_reg;
    logic                cap_zero_reg;

    logic signed [SAMPLE_W-1:0] centre_reg, up_reg, down_reg, left_reg, right_reg;
    logic signed [SAMPLE_W-1:0] cap_val;

    logic signed [WEIGHT_W-1:0] mul_w;
    logic signed [SAMPLE_W-1:0] mul_x;
    logic signed [PROD_W-1:0]   prod_next, prod_reg;
    logic                       prod_vld_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    logic signed [ACC_W-17:0]   lap_full;
    logic signed [LAP_W-1:0]    lap_next, lap_reg;
    logic signed [GAIN_W:0]     gain_s;
    logic signed [LAP_W+GAIN_W:0] gp_next, gp_reg;
    logic signed [LAP_W:0]      inc;
    logic signed [LAP_W+1:0]    sum;
    logic signed [SAMPLE_W-1:0] nv_sat, nv_next;

    logic out_valid_reg;

    // line store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_sample ? down_reg : centre_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    assign cap_val = cap_zero_reg ? '0 : signed'(rd_data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_en_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_en_reg   <= cmd.rd_en;
            prod_vld_reg <= cmd.mul_en;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cap_tgt_reg  <= cmd.rd_tgt;
        cap_zero_reg <= cmd.rd_zero;
        if (cmd.ld_sample)
        begin
            down_reg <= sample;
        end
        else if (cmd.clr_down)
        begin
            down_reg <= '0;
        end
        if (cap_en_reg)
        begin
            case (cap_tgt_reg)
                OP_CENTRE: centre_reg <= cap_val;
                OP_UP:     up_reg     <= cap_val;
                OP_LEFT:   left_reg   <= cap_val;
                OP_RIGHT:  right_reg  <= cap_val;
                default:   down_reg   <= cap_val;
            endcase
        end
    end

    // one weight-times-operand product per cycle
    always_comb
    begin
        case (cmd.mul_op)
            OP_UP:    begin mul_w = weight_v; mul_x = up_reg;     end
            OP_DOWN:  begin mul_w = weight_v; mul_x = down_reg;   end
            OP_LEFT:  begin mul_w = weight_h; mul_x = left_reg;   end
            OP_RIGHT: begin mul_w = weight_h; mul_x = right_reg;  end
            default:  begin mul_w = weight_c; mul_x = centre_reg; end
        endcase
    end

    assign prod_next = mul_w * mul_x;

    // floor(sum / 2^16) then clamp to 48 bits
    assign lap_full = acc_reg[ACC_W-1:16];
    always_comb
    begin
        if (lap_full[ACC_W-17:LAP_W-1] == '0 || lap_full[ACC_W-17:LAP_W-1] == '1)
        begin
            lap_next = lap_full[LAP_W-1:0];
        end
        else
        begin
            lap_next = {lap_full[ACC_W-17], {(LAP_W-1){~lap_full[ACC_W-17]}}};
        end
    end

    assign gain_s  = signed'({1'b0, step_gain});
    assign gp_next = gain_s * lap_reg;
    assign inc     = gp_reg[LAP_W+GAIN_W:16];
    assign sum     = {{(LAP_W+2-SAMPLE_W){centre_reg[SAMPLE_W-1]}}, centre_reg}
                   + {inc[LAP_W], inc};

    always_comb
    begin
        if (sum[LAP_W+1:SAMPLE_W-1] == '0 || sum[LAP_W+1:SAMPLE_W-1] == '1)
        begin
            nv_sat = sum[SAMPLE_W-1:0];
        end
        else
        begin
            nv_sat = {sum[LAP_W+1], {(SAMPLE_W-1){~sum[LAP_W+1]}}};
        end
        nv_next = cmd.border ? centre_reg : nv_sat;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        if (cmd.lap_en)
        begin
            lap_reg <= lap_next;
        end
        if (cmd.gain_en)
        begin
            gp_reg <= gp_next;
        end
        if (cmd.out_load)
        begin
            new_value  <= nv_next;
            laplacian  <= lap_reg;
            on_border  <= cmd.border;
            frame_last <= cmd.last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

// File: hdl/dss_ctrl.sv
// Sequencer: position counters, line-store addressing, compute and flush steps.
// Depends on dss_pkg; drives dss_datapath.
module dss_ctrl
    import dss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [COL_W-1:0]  grid_width,
    input  logic [ROW_W-1:0]  grid_height,
    input  logic              in_valid,
    output logic              in_ready,
    input  dp_status_t        status,
    output dp_cmd_t           cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_CAP, S_WRL,
        S_MUL, S_SUM, S_LAP, S_GAIN, S_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] pos_reg, pos_next;
    logic             up_zero_reg, up_zero_next;
    logic             border_reg, border_next;
    logic             emit_reg, emit_next;
    logic             flush_pend_reg, flush_pend_next;
    logic             flushing_reg, flushing_next;
    logic [2:0]       mul_idx_reg, mul_idx_next;

    logic [COL_W-1:0] w_eff, w_last;
    logic [ROW_W-1:0] h_eff;
    logic [COL_W-1:0] c_in;
    logic [ROW_W-1:0] r_in;
    logic             pos_first, pos_end;

    assign w_eff     = (grid_width < COL_W'(3)) ? COL_W'(3) : grid_width;
    assign h_eff     = (grid_height < ROW_W'(3)) ? ROW_W'(3) : grid_height;
    assign w_last    = w_eff - COL_W'(1);
    assign pos_first = (pos_reg == '0);
    assign pos_end   = (pos_reg == w_last);

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        if (col_reg >= w_eff || row_reg >= h_eff)
        begin
            c_in = '0;
            r_in = '0;
        end
        else
        begin
            c_in = col_reg;
            r_in = row_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        pos_next        = pos_reg;
        up_zero_next    = up_zero_reg;
        border_next     = border_reg;
        emit_next       = emit_reg;
        flush_pend_next = flush_pend_reg;
        flushing_next   = flushing_reg;
        mul_idx_next    = mul_idx_reg;

        cmd           = '0;
        cmd.rd_tgt    = OP_CENTRE;
        cmd.mul_op    = OP_CENTRE;
        cmd.border    = flushing_reg || border_reg;
        cmd.last      = flushing_reg && pos_end;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.ld_sample   = 1'b1;
                    pos_next        = c_in;
                    up_zero_next    = (r_in < ROW_W'(2));
                    border_next     = (r_in == ROW_W'(1)) || (c_in == '0) || (c_in == w_last);
                    emit_next       = (r_in != '0);
                    flush_pend_next = (c_in == w_last) && (r_in == h_eff - ROW_W'(1));
                    if (c_in == w_last && r_in == h_eff - ROW_W'(1))
                    begin
                        col_next = '0;
                        row_next = '0;
                    end
                    else if (c_in == w_last)
                    begin
                        col_next = '0;
                        row_next = r_in + ROW_W'(1);
                    end
                    else
                    begin
                        col_next = c_in + COL_W'(1);
                        row_next = r_in;
                    end
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = LOWER_BASE + ADDR_W'(pos_reg);
                cmd.rd_tgt  = OP_CENTRE;
                cmd.acc_clr = 1'b1;
                state_next  = S_RD1;
            end
            S_RD1:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = ADDR_W'(pos_reg);
                cmd.rd_tgt  = OP_UP;
                cmd.rd_zero = !flushing_reg && up_zero_reg;
                state_next  = S_RD2;
            end
            S_RD2:
            begin
                // left neighbor: already moved to the upper half, or in the lower half while flushing
                cmd.rd_en   = 1'b1;
                cmd.rd_tgt  = OP_LEFT;
                cmd.rd_zero = pos_first;
                if (pos_first)
                begin
                    cmd.rd_addr = '0;
                end
                else if (flushing_reg)
                begin
                    cmd.rd_addr = LOWER_BASE + ADDR_W'(pos_reg - COL_W'(1));
                end
                else
                begin
                    cmd.rd_addr = ADDR_W'(pos_reg - COL_W'(1));
                end
                state_next = S_RD3;
            end
            S_RD3:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_tgt  = OP_RIGHT;
                cmd.rd_zero = pos_end;
                cmd.rd_addr = pos_end ? LOWER_BASE + ADDR_W'(pos_reg)
                                      : LOWER_BASE + ADDR_W'(pos_reg + COL_W'(1));
                state_next  = S_CAP;
            end
            S_CAP:
            begin
                mul_idx_next = '0;
                if (flushing_reg)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = ADDR_W'(pos_reg);
                    state_next  = S_WRL;
                end
            end
            S_WRL:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_sample = 1'b1;
                cmd.wr_addr   = LOWER_BASE + ADDR_W'(pos_reg);
                state_next    = emit_reg ? S_MUL : S_IDLE;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                case (mul_idx_reg)
                    3'd0:    cmd.mul_op = OP_UP;
                    3'd1:    cmd.mul_op = OP_DOWN;
                    3'd2:    cmd.mul_op = OP_LEFT;
                    3'd3:    cmd.mul_op = OP_RIGHT;
                    default: cmd.mul_op = OP_CENTRE;
                endcase
                mul_idx_next = mul_idx_reg + 3'd1;
                if (mul_idx_reg == 3'd4)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = S_LAP;
            end
            S_LAP:
            begin
                cmd.lap_en = 1'b1;
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                cmd.gain_en = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (flushing_reg)
                    begin
                        if (pos_end)
                        begin
                            flushing_next = 1'b0;
                            state_next    = S_IDLE;
                        end
                        else
                        begin
                            pos_next   = pos_reg + COL_W'(1);
                            state_next = S_RD0;
                        end
                    end
                    else if (flush_pend_reg)
                    begin
                        // frame done: walk the last row with no row below
                        flush_pend_next = 1'b0;
                        flushing_next   = 1'b1;
                        cmd.clr_down    = 1'b1;
                        pos_next        = '0;
                        state_next      = S_RD0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            pos_reg        <= '0;
            up_zero_reg    <= 1'b0;
            border_reg     <= 1'b0;
            emit_reg       <= 1'b0;
            flush_pend_reg <= 1'b0;
            flushing_reg   <= 1'b0;
            mul_idx_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            pos_reg        <= pos_next;
            up_zero_reg    <= up_zero_next;
            border_reg     <= border_next;
            emit_reg       <= emit_next;
            flush_pend_reg <= flush_pend_next;
            flushing_reg   <= flushing_next;
            mul_idx_reg    <= mul_idx_next;
        end
    end

endmodule

// File: hdl/diffusion_stencil_step.sv
// Top level of the streaming diffusion stencil step: config registers,
// sequencer and datapath. Depends on dss_pkg, dss_if, dss_ctrl, dss_datapath.
//
// Usage:
//   smp carries grid samples (Q8.24) in raster order; a transfer happens when
//   valid and ready are both high. res carries one result per transfer:
//   updated value, saturated Laplacian, border flag and last-cell flag.
//   The config port (cfg_we, cfg_index, cfg_data) writes grid_width,
//   grid_height, the three stencil weights and step_gain; write only while
//   idle.
// Sequence:
//   One item at a time. A sample in the first row only passes the line-store
//   reads and writes and yields no result; any other sample runs until its
//   result is loaded into the output register: 4 line-store reads plus 2
//   writes (one read port, one write port), then 5 products through one
//   shared 32x32 multiplier, sum, clamp and gain. The last sample of a frame
//   also flushes the last row out, one result per cell of that row.
// Reset:
//   Counters go to row 0, column 0; registers take their defaults. The line
//   store is not cleared; every entry used is written earlier in the frame.
// Stalls:
//   A held result sits in the output register; the next result waits in the
//   emit step until res.ready frees the register, and input waits with it.
module diffusion_stencil_step
    import dss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    dss_sample_if.sink            smp,
    dss_result_if.source          res
);

    logic [COL_W-1:0]           grid_width_reg;
    logic [ROW_W-1:0]           grid_height_reg;
    logic signed [WEIGHT_W-1:0] weight_h_reg;
    logic signed [WEIGHT_W-1:0] weight_v_reg;
    logic signed [WEIGHT_W-1:0] weight_c_reg;
    logic [GAIN_W-1:0]          step_gain_reg;

    dp_cmd_t    cmd;
    dp_status_t status;

    // register file; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= RST_GRID_WIDTH;
            grid_height_reg <= RST_GRID_HEIGHT;
            weight_h_reg    <= RST_WEIGHT_H;
            weight_v_reg    <= RST_WEIGHT_V;
            weight_c_reg    <= RST_WEIGHT_C;
            step_gain_reg   <= RST_STEP_GAIN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[COL_W-1:0];
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[ROW_W-1:0];
                CFG_WEIGHT_H:    weight_h_reg    <= signed'(cfg_data[WEIGHT_W-1:0]);
                CFG_WEIGHT_V:    weight_v_reg    <= signed'(cfg_data[WEIGHT_W-1:0]);
                CFG_WEIGHT_C:    weight_c_reg    <= signed'(cfg_data[WEIGHT_W-1:0]);
                CFG_STEP_GAIN:   step_gain_reg   <= cfg_data[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    dss_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .in_valid    (smp.valid),
        .in_ready    (smp.ready),
        .status      (status),
        .cmd         (cmd)
    );

    dss_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .sample     (smp.sample),
        .weight_h   (weight_h_reg),
        .weight_v   (weight_v_reg),
        .weight_c   (weight_c_reg),
        .step_gain  (step_gain_reg),
        .out_ready  (res.ready),
        .out_valid  (res.valid),
        .new_value  (res.new_value),
        .laplacian  (res.laplacian),
        .on_border  (res.on_border),
        .frame_last (res.frame_last)
    );

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for diffusion_stencil_step: streams grid frames,
// predicts every cell update in the testbench and compares each result transfer.
// Depends on dss_pkg, dss_if and the RTL under hdl/.
module tb_top;
    import dss_pkg::*;

    // result of one cell as the block should report it
    typedef struct {
        logic signed [SAMPLE_W-1:0] new_value;
        logic signed [LAP_W-1:0]    laplacian;
        logic                       on_border;
        logic                       frame_last;
    } cell_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dss_sample_if smp ();
    dss_result_if res ();

    diffusion_stencil_step u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .smp       (smp.sink),
        .res       (res.source)
    );

    // predictor copy of registers and position
    logic [5:0]                  grid_w_reg;
    logic [15:0]                 grid_h_reg;
    logic signed [WEIGHT_W-1:0]  wt_horiz;
    logic signed [WEIGHT_W-1:0]  wt_vert;
    logic signed [WEIGHT_W-1:0]  wt_centre;
    logic [GAIN_W-1:0]           gain_reg;
    // two rows of samples: [0..MAX_WIDTH-1] older row, [MAX_WIDTH..] newer row
    logic signed [SAMPLE_W-1:0]  row_mem [0:2*MAX_WIDTH-1];
    int                          col_pos;
    int                          row_pos;

    cell_result_t expected_cells[$];

    int send_idle_pct;   // chance in percent of a gap before each sample
    int recv_idle_pct;   // chance in percent that ready is low in a cycle
    int hold_left;       // long receiver hold-off, counted down below
    int mismatches;
    int samples_sent;
    int cells_checked;
    int frames_done;

    // clock: period 4
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // 5-point stencil with floor division by 2^16, saturated to 48 bits,
    // then gain update (border cells pass the centre through).
    function automatic cell_result_t stencil_cell(
        input logic signed [31:0] centre,
        input logic signed [31:0] up,
        input logic signed [31:0] down,
        input logic signed [31:0] left,
        input logic signed [31:0] right,
        input logic               border,
        input logic               last
    );
        logic signed [71:0] acc;
        logic signed [71:0] lap_full;
        logic signed [47:0] lap;
        logic signed [71:0] scaled;
        logic signed [71:0] upd;
        cell_result_t       r;
        acc = wt_vert * up + wt_vert * down + wt_horiz * left
            + wt_horiz * right + wt_centre * centre;
        lap_full = acc >>> 16;
        if (lap_full > 72'sh7FFF_FFFF_FFFF)
            lap = 48'sh7FFF_FFFF_FFFF;
        else if (lap_full < -72'sh8000_0000_0000)
            lap = -48'sh8000_0000_0000;
        else
            lap = lap_full[47:0];
        scaled = $signed({1'b0, gain_reg}) * lap;
        upd = centre + (scaled >>> 16);
        if (border)
            r.new_value = centre;
        else if (upd > 72'sh7FFF_FFFF)
            r.new_value = 32'sh7FFF_FFFF;
        else if (upd < -72'sh8000_0000)
            r.new_value = -32'sh8000_0000;
        else
            r.new_value = upd[31:0];
        r.laplacian  = lap;
        r.on_border  = border;
        r.frame_last = last;
        return r;
    endfunction

    // Advance the grid model by one accepted sample and queue what it emits.
    task automatic predict_sample(input logic signed [31:0] s);
        int w;
        int h;
        int c;
        int r;
        logic signed [31:0] up;
        logic signed [31:0] left;
        logic signed [31:0] right;
        w = (grid_w_reg < 3) ? 3 : grid_w_reg;
        h = (grid_h_reg < 3) ? 3 : grid_h_reg;
        c = col_pos;
        r = row_pos;
        // position outside shrunken geometry: frame restarts here
        if (c >= w || r >= h)
        begin
            c = 0;
            r = 0;
        end
        if (r >= 1)
        begin
            up    = (r >= 2) ? row_mem[c] : 32'sd0;
            left  = (c > 0) ? row_mem[c-1] : 32'sd0;
            right = (c < w - 1) ? row_mem[MAX_WIDTH+c+1] : 32'sd0;
            expected_cells.push_back(stencil_cell(row_mem[MAX_WIDTH+c], up, s, left,
                right, (r == 1) || (c == 0) || (c == w - 1), 1'b0));
        end
        row_mem[c] = row_mem[MAX_WIDTH+c];
        row_mem[MAX_WIDTH+c] = s;
        if (c == w - 1 && r == h - 1)
        begin
            // last sample flushes the bottom row, all border cells
            for (int k = 0; k < w; k++)
            begin
                left  = (k > 0) ? row_mem[MAX_WIDTH+k-1] : 32'sd0;
                right = (k < w - 1) ? row_mem[MAX_WIDTH+k+1] : 32'sd0;
                expected_cells.push_back(stencil_cell(row_mem[MAX_WIDTH+k], row_mem[k],
                    32'sd0, left, right, 1'b1, k == w - 1));
            end
            col_pos = 0;
            row_pos = 0;
            frames_done++;
        end
        else if (c == w - 1)
        begin
            col_pos = 0;
            row_pos = r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Config write; caller must be at a posedge with the block idle.
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_GRID_WIDTH:  grid_w_reg = value[5:0];
            CFG_GRID_HEIGHT: grid_h_reg = value[15:0];
            CFG_WEIGHT_H:    wt_horiz   = value;
            CFG_WEIGHT_V:    wt_vert    = value;
            CFG_WEIGHT_C:    wt_centre  = value;
            CFG_STEP_GAIN:   gain_reg   = value[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_geometry(input int w, input int h);
        write_reg(CFG_GRID_WIDTH, 32'(w));
        write_reg(CFG_GRID_HEIGHT, 32'(h));
    endtask

    task automatic set_weights(input logic [31:0] wh, input logic [31:0] wv,
                               input logic [31:0] wc, input logic [31:0] g);
        write_reg(CFG_WEIGHT_H, wh);
        write_reg(CFG_WEIGHT_V, wv);
        write_reg(CFG_WEIGHT_C, wc);
        write_reg(CFG_STEP_GAIN, g);
    endtask

    // One sample transfer; valid stays high afterwards so back-to-back
    // samples keep valid asserted between transfers.
    task automatic push_sample(input logic signed [31:0] s);
        if ($urandom_range(99) < send_idle_pct)
        begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        smp.valid  <= 1'b1;
        smp.sample <= s;
        do
            @(posedge clk);
        while (!smp.ready);
        samples_sent++;
        predict_sample(s);
    endtask

    // Drop valid, wait for every expected cell, then let any result-free
    // sample still inside the block finish.
    task automatic wait_idle();
        smp.valid <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(65535)) - 32768) <<< 8;
            default: return 32'($signed($urandom_range(1 << 26)) - (1 << 25));
        endcase
    endfunction

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom;
            default: return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
        endcase
    endfunction

    // Whole frame of random samples at the current geometry.
    task automatic send_frame();
        int n;
        n = ((grid_w_reg < 3) ? 3 : grid_w_reg) * ((grid_h_reg < 3) ? 3 : grid_h_reg);
        repeat (n) push_sample(rand_sample());
    endtask

    // ------------------------------------------------------------------
    // Receiver and result checker
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            res.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cell_result_t exp_c;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_cells.size() == 0)
            begin
                $display("%0t: unexpected result new_value=%h laplacian=%h", $time,
                         res.new_value, res.laplacian);
                mismatches++;
            end
            else
            begin
                exp_c = expected_cells.pop_front();
                cells_checked++;
                if (res.new_value !== exp_c.new_value)
                begin
                    $display("%0t: new_value expected %h actual %h", $time,
                             exp_c.new_value, res.new_value);
                    mismatches++;
                end
                if (res.laplacian !== exp_c.laplacian)
                begin
                    $display("%0t: laplacian expected %h actual %h", $time,
                             exp_c.laplacian, res.laplacian);
                    mismatches++;
                end
                if (res.on_border !== exp_c.on_border)
                begin
                    $display("%0t: on_border expected %b actual %b", $time,
                             exp_c.on_border, res.on_border);
                    mismatches++;
                end
                if (res.frame_last !== exp_c.frame_last)
                begin
                    $display("%0t: frame_last expected %b actual %b", $time,
                             exp_c.frame_last, res.frame_last);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Smallest grid with register values below the floor (width 0, height 1
    // both act as 3), extreme weights and full gain; samples at the extremes.
    task automatic test_extremes();
        set_geometry(0, 1);
        set_weights(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF);
        push_sample(32'sh7FFF_FFFF);
        push_sample(-32'sh8000_0000);
        push_sample(32'sh7FFF_FFFF);
        push_sample(32'sh0);
        push_sample(32'sh7FFF_FFFF);
        push_sample(-32'sh1);
        push_sample(-32'sh8000_0000);
        push_sample(32'sh1);
        push_sample(32'sh7FFF_FFFF);
        wait_idle();
        // same grid, zero gain and opposite-sign extremes
        set_weights(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        repeat (9) push_sample(rand_sample());
        wait_idle();
    endtask

    // Width shrinks below the current column mid-frame: the next sample
    // starts a fresh frame. Then the tallest height, shrunk after three rows.
    task automatic test_restart();
        set_weights(32'd65536, 32'd65536, -32'sd262144, 32'd6553);
        set_geometry(6, 3);
        repeat (4) push_sample(rand_sample());
        wait_idle();
        write_reg(CFG_GRID_WIDTH, 32'd3);
        send_frame();
        wait_idle();
        set_geometry(3, 65535);
        repeat (9) push_sample(rand_sample());
        wait_idle();
        write_reg(CFG_GRID_HEIGHT, 32'd3);
        send_frame();
        wait_idle();
    endtask

    // Receiver holds off for a long stretch while samples keep coming, so
    // the output register fills and input transfers stall.
    task automatic test_backpressure();
        set_geometry(10, 3);
        hold_left = 400;
        send_frame();
        wait_idle();
    endtask

    // Random frames, new settings between frames, until about n samples.
    task automatic test_random(input int n);
        int start;
        start = samples_sent;
        while (samples_sent - start < n)
        begin
            set_geometry($urandom_range(9, 3), $urandom_range(5, 3));
            set_weights(rand_weight(), rand_weight(), rand_weight(),
                        ($urandom_range(3) == 0) ? 32'hFFFF : $urandom_range(65535));
            send_frame();
            wait_idle();
        end
    endtask

    // widest grid: the first row and the start of the second, so both ends
    // of each line-store half are written and the first cells come out
    task automatic test_max_width();
        set_geometry(MAX_WIDTH, 3);
        set_weights(rand_weight(), rand_weight(), rand_weight(), $urandom_range(65535));
        repeat (MAX_WIDTH + 3) push_sample(rand_sample());
        wait_idle();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        smp.valid  = 1'b0;
        smp.sample = '0;
        hold_left  = 0;
        mismatches = 0;
        samples_sent  = 0;
        cells_checked = 0;
        frames_done   = 0;
        send_idle_pct = 9;
        recv_idle_pct = 61;
        grid_w_reg = RST_GRID_WIDTH;
        grid_h_reg = RST_GRID_HEIGHT;
        wt_horiz   = RST_WEIGHT_H;
        wt_vert    = RST_WEIGHT_V;
        wt_centre  = RST_WEIGHT_C;
        gain_reg   = RST_STEP_GAIN;
        col_pos    = 0;
        row_pos    = 0;
        for (int i = 0; i < 2 * MAX_WIDTH; i++)
            row_mem[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_restart();
        test_backpressure();
        test_random(15);
        send_idle_pct = 61;
        recv_idle_pct = 9;
        test_random(15);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(15);
        test_max_width();

        $display("Checked %0d cell results from %0d samples over %0d complete frames,",
                 cells_checked, samples_sent, frames_done);
        $display("incl. saturating weights, mid-frame restarts and a long output stall.");
        if (mismatches == 0 && expected_cells.size() == 0)
            $display("[diffusion_stencil_step] OK");
        else
            $display("[diffusion_stencil_step] ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #8000000;
        $display("Timeout with %0d results outstanding", expected_cells.size());
        $display("[diffusion_stencil_step] ERROR");
        $finish;
    end

endmodule

// File: diffusion_stencil_step.f
hdl/dss_pkg.sv
hdl/dss_if.sv
hdl/dss_datapath.sv
hdl/dss_ctrl.sv
hdl/diffusion_stencil_step.sv
dv/tb_top.sv
